// File: rtl/core/glob_wildcard_matcher_macros.svh
// assertion macros shared by the glob matcher rtl
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// same-cycle implication, checked on aclk, off while aresetn is low
`define GWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk, off while aresetn is low
`define GWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gwm_pkg.sv
// shared types, character codes and helpers for the glob matcher
package gwm_pkg;

    // word kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_SUBJECT = 2'd2,
        ACT_END     = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CASE_FOLD      = 2'd0,
        REG_STAR_NEEDS_ONE = 2'd1,
        REG_SEP_BYTES      = 2'd2,
        REG_SEP_COUNT      = 2'd3
    } reg_idx_t;

    localparam logic [7:0]  CH_QUESTION   = 8'h3F;
    localparam logic [7:0]  CH_STAR       = 8'h2A;
    localparam logic [7:0]  CH_UPPER_A    = 8'h41;
    localparam logic [7:0]  CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET   = 8'h20;
    localparam logic [63:0] SEP_BYTES_RST = 64'h0000_0000_003A_5C2F;
    localparam logic [3:0]  SEP_COUNT_RST = 4'd3;
    localparam int          SEP_SLOTS     = 8;

    // one input word after the input register
    typedef struct packed {
        action_t    action;
        logic [7:0] byte_value;
    } item_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic        case_fold;
        logic        star_needs_one;
        logic [63:0] separator_bytes;
        logic [3:0]  separator_count;
    } cfg_t;

    // fold upper case letters to lower case when enabled
    function automatic logic [7:0] fold_case(input logic [7:0] c, input logic en);
        if (en && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/gwm_pattern_store.sv
// pattern byte store with length counter and sticky overflow flag
`include "glob_wildcard_matcher_macros.svh"

module gwm_pattern_store #(
    parameter  int MAX_PATTERN = 63,
    localparam int LenW        = $clog2(MAX_PATTERN + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  gwm_pkg::item_t                item,
    output logic [MAX_PATTERN-1:0][7:0]   pat,
    output logic [LenW-1:0]               pat_len,
    output logic                          pat_ovf
);
    import gwm_pkg::*;

    logic [MAX_PATTERN-1:0][7:0] store_reg;
    logic [LenW-1:0]             len_reg, len_next;
    logic                        ovf_reg, ovf_next;
    logic                        do_append;
    logic                        is_full;

    assign do_append = step_en && item.action == ACT_APPEND && item.byte_value != 8'h00;
    assign is_full   = len_reg == LenW'(MAX_PATTERN);

    // length and overflow update
    always_comb begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (step_en && item.action == ACT_CLEAR) begin
            len_next = '0;
            ovf_next = 1'b0;
        end else if (do_append) begin
            if (is_full) begin
                ovf_next = 1'b1;
            end else begin
                len_next = len_reg + LenW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    // each entry loads when the length points at it
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (do_append && len_reg == LenW'(i)) begin
                store_reg[i] <= item.byte_value;
            end
        end
    end

    assign pat     = store_reg;
    assign pat_len = len_reg;
    assign pat_ovf = ovf_reg;

    `GWM_ASSERT_NEXT(a_clear_empties, step_en && item.action == ACT_CLEAR, len_reg == '0 && !ovf_reg, "clear left pattern state behind")
    `GWM_ASSERT_NEXT(a_full_sets_ovf, do_append && is_full, ovf_reg && len_reg == LenW'(MAX_PATTERN), "append to full store did not flag overflow")

endmodule

// File: rtl/core/gwm_nfa.sv
// bit-vector nfa over pattern positions: star closure and one-byte advance
`include "glob_wildcard_matcher_macros.svh"

module gwm_nfa #(
    parameter  int MAX_PATTERN = 63,
    localparam int LenW        = $clog2(MAX_PATTERN + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  gwm_pkg::item_t                item,
    input  gwm_pkg::cfg_t                 cfg,
    input  logic [MAX_PATTERN-1:0][7:0]   pat,
    input  logic [LenW-1:0]               pat_len,
    output logic                          end_hit
);
    import gwm_pkg::*;

    localparam int VecW   = MAX_PATTERN + 1;
    localparam int Levels = $clog2(VecW);

    logic [VecW-1:0]        active_reg, active_next;
    logic [VecW-1:0]        len_mask, cur, nxt;
    logic [MAX_PATTERN-1:0] pos_valid, is_star, is_quest, lit_hit;
    logic                   sep;

    // per-position pattern classes and literal compare
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pos_valid[i] = LenW'(i) < pat_len;
            is_star[i]   = pat[i] == CH_STAR;
            is_quest[i]  = pat[i] == CH_QUESTION;
            lit_hit[i]   = fold_case(pat[i], cfg.case_fold)
                           == fold_case(item.byte_value, cfg.case_fold);
        end
        for (int i = 0; i < VecW; i++) begin
            len_mask[i] = LenW'(i) <= pat_len;
        end
    end

    // separator lookup, counts above eight act as eight
    always_comb begin
        sep = 1'b0;
        for (int k = 0; k < SEP_SLOTS; k++) begin
            if (4'(k) < cfg.separator_count
                    && cfg.separator_bytes[8*k +: 8] == item.byte_value) begin
                sep = 1'b1;
            end
        end
    end

    // star closure as a parallel prefix: a live star position lights the next one, unless star_needs_one is set
    always_comb begin
        logic [VecW-1:0] g;
        logic [VecW-1:0] p;
        g = active_reg & len_mask;
        p = {is_star & pos_valid, 1'b0} & {VecW{!cfg.star_needs_one}};
        for (int lvl = 0; lvl < Levels; lvl++) begin
            g = g | (p & (g << (1 << lvl)));
            p = p & (p << (1 << lvl));
        end
        cur = g;
    end

    // advance every live position by one subject byte
    always_comb begin
        nxt = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (cur[i] && pos_valid[i]) begin
                if (is_quest[i]) begin
                    nxt[i+1] = nxt[i+1] | !sep;
                end else if (is_star[i]) begin
                    if (!cfg.star_needs_one) begin
                        nxt[i] = nxt[i] | !sep;
                    end else begin
                        nxt[i+1] = nxt[i+1] | !sep;
                    end
                end else begin
                    nxt[i+1] = nxt[i+1] | lit_hit[i];
                end
            end
            // least-one mode: the position after a star keeps soaking up bytes
            if (cfg.star_needs_one && !sep && cur[i+1] && pos_valid[i] && is_star[i]) begin
                nxt[i+1] = 1'b1;
            end
        end
    end

    // state update per word kind
    always_comb begin
        active_next = active_reg;
        if (step_en) begin
            unique case (item.action)
                ACT_CLEAR:   active_next = VecW'(1);
                ACT_END:     active_next = VecW'(1);
                ACT_SUBJECT: active_next = (item.byte_value != 8'h00) ? nxt : active_reg;
                ACT_APPEND:  active_next = active_reg;
                default:     active_next = active_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= VecW'(1);
        end else begin
            active_reg <= active_next;
        end
    end

    assign end_hit = cur[pat_len];

    `GWM_ASSERT_NEXT(a_rearm, step_en && (item.action == ACT_CLEAR || item.action == ACT_END), active_reg == VecW'(1), "matcher not rearmed after clear or end")

endmodule

// File: rtl/core/glob_wildcard_matcher.sv
// glob matcher top level: input register, nfa step, result register
// flow: an accepted word is held in the input register, then processed by the nfa step; an end word
//   loads its result into the result register, which drives m_tdata
// throughput: one word per cycle, but an end word waits while an untaken result is still held
// reset: synchronous active-low aresetn empties the pattern, clears overflow, rearms position 0
//   and loads the configuration defaults (slash, backslash, colon as separators)
`include "glob_wildcard_matcher_macros.svh"

module glob_wildcard_matcher #(
    parameter int MAX_PATTERN = 63
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [63:0] cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_value
    input  logic [1:0]  s_tuser,    // [1:0] action
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [0] matched, [1] pattern_overflow, [7:2] zero
);
    import gwm_pkg::*;

    localparam int LenW = $clog2(MAX_PATTERN + 1);

    cfg_t                        cfg_reg;
    logic                        in_vld_reg;
    item_t                       in_item_reg;
    logic                        out_vld_reg;
    logic                        out_match_reg;
    logic                        out_ovf_reg;
    logic                        advance;
    logic                        step_en;
    logic                        is_end;
    logic [MAX_PATTERN-1:0][7:0] pat;
    logic [LenW-1:0]             pat_len;
    logic                        pat_ovf;
    logic                        end_hit;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.case_fold       <= 1'b0;
            cfg_reg.star_needs_one  <= 1'b0;
            cfg_reg.separator_bytes <= SEP_BYTES_RST;
            cfg_reg.separator_count <= SEP_COUNT_RST;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_idx))
                REG_CASE_FOLD:      cfg_reg.case_fold       <= cfg_wdata[0];
                REG_STAR_NEEDS_ONE: cfg_reg.star_needs_one  <= cfg_wdata[0];
                REG_SEP_BYTES:      cfg_reg.separator_bytes <= cfg_wdata;
                REG_SEP_COUNT:      cfg_reg.separator_count <= cfg_wdata[3:0];
                default:            cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // an end word waits only while the result register is full and m_tready is low
    assign is_end   = in_item_reg.action == ACT_END;
    assign advance  = !is_end || !out_vld_reg || m_tready;
    assign step_en  = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action     <= action_t'(s_tuser);
            in_item_reg.byte_value <= s_tdata;
        end
    end

    gwm_pattern_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .pat     (pat),
        .pat_len (pat_len),
        .pat_ovf (pat_ovf)
    );

    gwm_nfa #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_nfa (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .pat     (pat),
        .pat_len (pat_len),
        .end_hit (end_hit)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step_en && is_end) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && is_end) begin
            out_match_reg <= end_hit && !pat_ovf;
            out_ovf_reg   <= pat_ovf;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_ovf_reg, out_match_reg};

    `GWM_ASSERT_NEXT(a_end_gives_word, step_en && is_end, out_vld_reg, "end word produced no result")
    `GWM_ASSERT_SAME(a_ovf_no_match, out_vld_reg, !(out_match_reg && out_ovf_reg), "match reported with overflowed pattern")

endmodule

// File: sim/testbench.sv
// self-checking testbench for the glob wildcard matcher: directed, mode and random tests
`timescale 1ns / 100ps

module testbench;
    import gwm_pkg::*;

    localparam int PAT_DEPTH   = 63;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic matched;
        logic overflow;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    reg_idx_t    cfg_idx;
    logic [63:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    // shadow of the matcher state and its configuration
    logic [7:0]  glob_pat [PAT_DEPTH];
    int unsigned glob_len;
    logic [63:0] live_pos;
    logic        pat_overflow;
    logic        fold_en;
    logic        star_one;
    logic [63:0] sep_set;
    logic [3:0]  sep_num;

    verdict_t pending_verdicts[$];
    int       mismatches = 0;
    logic     no_gaps = 1'b0;

    glob_wildcard_matcher u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // positions that exist for the current pattern length
    function automatic logic [63:0] pos_mask();
        if (glob_len >= PAT_DEPTH) begin
            return '1;
        end
        return (64'd1 << (glob_len + 1)) - 64'd1;
    endfunction

    function automatic logic sep_hit(logic [7:0] b);
        int n;
        int k;
        n = (sep_num > 4'd8) ? 8 : int'(sep_num);
        for (k = 0; k < n; k++) begin
            if (sep_set[8*k +: 8] == b) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        if (fold_en && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    // an active star lets the position after it start too, unless star needs a byte
    function automatic logic [63:0] star_closure(logic [63:0] v);
        int i;
        v &= pos_mask();
        if (star_one) begin
            return v;
        end
        for (i = 0; i < glob_len; i++) begin
            if (v[i] && glob_pat[i] == CH_STAR) begin
                v[i+1] = 1'b1;
            end
        end
        return v;
    endfunction

    // one subject byte through every active position
    function automatic logic [63:0] step_positions(logic [63:0] cur, logic [7:0] b);
        logic [63:0] nxt;
        logic        sep;
        logic        hit;
        logic [7:0]  p;
        int          i;
        nxt = '0;
        sep = sep_hit(b);
        for (i = 0; i < glob_len; i++) begin
            if (!cur[i]) begin
                continue;
            end
            p = glob_pat[i];
            if (p == CH_QUESTION) begin
                hit = !sep;
            end else if (p == CH_STAR) begin
                if (!star_one) begin
                    if (!sep) begin
                        nxt[i] = 1'b1;
                    end
                    hit = 1'b0;
                end else begin
                    hit = !sep;
                end
            end else begin
                hit = (to_lower(p) == to_lower(b));
            end
            if (hit) begin
                nxt[i+1] = 1'b1;
            end
        end
        // in one-or-more mode the position after a star keeps eating bytes
        if (star_one && !sep) begin
            for (i = 1; i <= glob_len; i++) begin
                if (cur[i] && glob_pat[i-1] == CH_STAR) begin
                    nxt[i] = 1'b1;
                end
            end
        end
        return nxt;
    endfunction

    // apply one accepted word to the shadow matcher
    task automatic glob_update(action_t act, logic [7:0] b);
        logic [63:0] cur;
        verdict_t    v;
        case (act)
            ACT_CLEAR: begin
                glob_len     = 0;
                pat_overflow = 1'b0;
                live_pos     = 64'd1;
            end
            ACT_APPEND: begin
                if (b != 8'd0) begin
                    if (glob_len >= PAT_DEPTH) begin
                        pat_overflow = 1'b1;
                    end else begin
                        glob_pat[glob_len] = b;
                        glob_len++;
                    end
                end
            end
            ACT_SUBJECT: begin
                if (b != 8'd0) begin
                    live_pos = step_positions(star_closure(live_pos), b);
                end
            end
            default: begin
                cur        = star_closure(live_pos);
                v.matched  = cur[glob_len] && !pat_overflow;
                v.overflow = pat_overflow;
                pending_verdicts.push_back(v);
                live_pos   = 64'd1;
            end
        endcase
    endtask

    // result check against the oldest verdict, then prediction of the accepted input word
    always @(posedge aclk) begin : word_monitor
        verdict_t want;
        if (aresetn === 1'b1) begin
            if (m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result word %h", m_tdata);
                    end
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_tdata[0] !== want.matched || m_tdata[1] !== want.overflow
                            || m_tdata[7:2] !== 6'd0) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result mismatch: expected matched %b overflow %b, got word %h",
                                     want.matched, want.overflow, m_tdata);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                glob_update(action_t'(s_tuser), s_tdata);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench failed");
        $finish;
    end

    // result side: random stall before each word
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(15);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // send one word after a random gap; returns at the edge that accepts it
    task automatic send_word(action_t act, logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the input until every verdict is in and the pipeline is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic put_reg(reg_idx_t idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // write all four registers; only called while the block is idle
    task automatic write_config(logic fold, logic one, logic [63:0] seps, logic [3:0] count);
        put_reg(REG_CASE_FOLD, {63'd0, fold});
        put_reg(REG_STAR_NEEDS_ONE, {63'd0, one});
        put_reg(REG_SEP_BYTES, seps);
        put_reg(REG_SEP_COUNT, {60'd0, count});
        cfg_we   <= 1'b0;
        fold_en  = fold;
        star_one = one;
        sep_set  = seps;
        sep_num  = count;
    endtask

    function automatic logic [7:0] pattern_byte();
        case ($urandom_range(15))
            0, 1, 2, 3, 4, 5: return "a" + 8'($urandom_range(2));
            6, 7:             return "A" + 8'($urandom_range(2));
            8, 9:             return CH_STAR;
            10:               return CH_QUESTION;
            11:               return "/";
            12:               return sep_set[7:0];
            13:               return 8'($urandom_range(255));
            14:               return 8'd0;
            default:          return ":";
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        case ($urandom_range(7))
            0, 1, 2, 3, 4, 5: return "a" + 8'($urandom_range(2));
            6:                return "A" + 8'($urandom_range(2));
            default:          return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if ($urandom_range(1) == 0) begin
            return c;
        end
        if (c >= "A" && c <= "Z") begin
            return c + CASE_OFFSET;
        end
        if (c >= "a" && c <= "z") begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    // mostly a pattern and a subject built to follow it, sometimes noise
    task automatic run_sequence();
        logic [7:0] pat[$];
        logic [7:0] c;
        int         plen;
        int         k;
        no_gaps = ($urandom_range(7) == 0);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                send_word(action_t'($urandom_range(3)), 8'($urandom_range(255)));
            end
            return;
        end
        send_word(ACT_CLEAR, 8'($urandom_range(255)));
        plen = ($urandom_range(24) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 7);
        for (k = 0; k < plen; k++) begin
            c = pattern_byte();
            send_word(ACT_APPEND, c);
            if (c != 8'd0) begin
                pat.push_back(c);
            end
        end
        for (k = 0; k < pat.size() && k < PAT_DEPTH; k++) begin
            if (pat[k] == CH_STAR) begin
                repeat ($urandom_range(0, 3)) send_word(ACT_SUBJECT, plain_byte());
            end else if (pat[k] == CH_QUESTION) begin
                send_word(ACT_SUBJECT, plain_byte());
            end else begin
                send_word(ACT_SUBJECT, flip_case(pat[k]));
            end
            // occasional break in the sequence, including a pattern change mid-subject
            if ($urandom_range(29) == 0) begin
                send_word(action_t'($urandom_range(1) ? ACT_APPEND : ACT_SUBJECT),
                          8'($urandom_range(255)));
            end
        end
        if ($urandom_range(5) == 0) begin
            send_word(ACT_SUBJECT, plain_byte());
        end
        send_word(ACT_END, 8'($urandom_range(255)));
    endtask

    // reset configuration: wildcards, ignored zero bytes, separators, literal separator,
    // empty pattern and subject, pattern grown mid-subject
    task automatic test_directed();
        send_word(ACT_CLEAR, 8'd0);
        send_word(ACT_END, 8'd0);
        send_word(ACT_APPEND, "a");
        send_word(ACT_APPEND, CH_STAR);
        send_word(ACT_APPEND, CH_QUESTION);
        send_word(ACT_APPEND, 8'd0);
        send_word(ACT_APPEND, "/");
        send_word(ACT_SUBJECT, "a");
        send_word(ACT_SUBJECT, 8'hFF);
        send_word(ACT_SUBJECT, 8'd0);
        send_word(ACT_SUBJECT, "x");
        send_word(ACT_SUBJECT, "/");
        send_word(ACT_END, 8'hFF);
        send_word(ACT_SUBJECT, "a");
        send_word(ACT_SUBJECT, "/");
        send_word(ACT_SUBJECT, "/");
        send_word(ACT_END, 8'd0);
        send_word(ACT_SUBJECT, "A");
        send_word(ACT_APPEND, 8'h80);
        send_word(ACT_SUBJECT, 8'h80);
        send_word(ACT_END, 8'd0);
    endtask

    // case folding, star needing a byte, separator count above eight and none at all
    task automatic test_modes();
        wait_drained();
        write_config(1'b1, 1'b1, SEP_BYTES_RST, 4'd15);
        send_word(ACT_CLEAR, 8'd0);
        send_word(ACT_APPEND, "A");
        send_word(ACT_APPEND, CH_STAR);
        send_word(ACT_APPEND, "b");
        send_word(ACT_SUBJECT, "a");
        send_word(ACT_SUBJECT, "b");
        send_word(ACT_END, 8'd0);
        send_word(ACT_SUBJECT, "a");
        send_word(ACT_SUBJECT, "Z");
        send_word(ACT_SUBJECT, "x");
        send_word(ACT_SUBJECT, "B");
        send_word(ACT_END, 8'd0);
        wait_drained();
        write_config(1'b1, 1'b0, 64'd0, 4'd0);
        send_word(ACT_CLEAR, 8'd0);
        send_word(ACT_APPEND, CH_QUESTION);
        send_word(ACT_APPEND, CH_STAR);
        send_word(ACT_SUBJECT, "/");
        send_word(ACT_SUBJECT, "\\");
        send_word(ACT_END, 8'd0);
    endtask

    // store full: the append past the last entry sets overflow until the next clear
    task automatic test_store_full();
        wait_drained();
        write_config(1'b0, 1'b0, '1, 4'd8);
        send_word(ACT_CLEAR, 8'd0);
        repeat (PAT_DEPTH + 1) send_word(ACT_APPEND, 8'($urandom_range(1, 255)));
        send_word(ACT_END, 8'd0);
        send_word(ACT_APPEND, CH_STAR);
        send_word(ACT_END, 8'd0);
        send_word(ACT_CLEAR, 8'd0);
        send_word(ACT_END, 8'd0);
    endtask

    // random sequences under a sweep of settings, extremes included
    task automatic test_random_configs();
        logic [63:0] seps;
        logic [3:0]  count;
        int          phase;
        for (phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase % 4)
                0: begin
                    seps  = SEP_BYTES_RST;
                    count = SEP_COUNT_RST;
                end
                1: begin
                    seps  = '0;
                    count = 4'd0;
                end
                2: begin
                    seps  = '1;
                    count = 4'd15;
                end
                default: begin
                    seps        = {$urandom(), $urandom()};
                    seps[7:0]   = "b";
                    seps[15:8]  = "/";
                    count       = 4'($urandom_range(15));
                end
            endcase
            write_config(phase[0], phase[1], seps, count);
            repeat (12) begin
                if ($urandom_range(19) == 0) begin
                    wait_drained();
                end
                run_sequence();
            end
        end
    endtask

    initial begin
        cfg_we    <= 1'b0;
        cfg_idx   <= REG_CASE_FOLD;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_CLEAR;
        aresetn   <= 1'b0;
        foreach (glob_pat[i]) begin
            glob_pat[i] = 8'd0;
        end
        glob_len     = 0;
        live_pos     = 64'd1;
        pat_overflow = 1'b0;
        fold_en      = 1'b0;
        star_one     = 1'b0;
        sep_set      = SEP_BYTES_RST;
        sep_num      = SEP_COUNT_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_modes();
        test_store_full();
        test_random_configs();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
